[rtl/core/filtered_chunk_hash_index_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the filtered chunk hash index block
// Simulation builds get concurrent checks. Synthesis builds get nothing.
// ----------------------------------------------------------------------------
`ifndef FILTERED_CHUNK_HASH_INDEX_ASSERT_SVH
`define FILTERED_CHUNK_HASH_INDEX_ASSERT_SVH

`ifndef SYNTHESIS
// Checks that an implication holds at every rising clock edge outside reset.
`define FCHI_ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checks that a condition never becomes true outside reset.
`define FCHI_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define FCHI_ASSERT_IMPL(label, clk, rst, prop, msg)
`define FCHI_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

[rtl/core/fchi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fchi_pkg
// Shared widths, constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package fchi_pkg;

  localparam int HashW   = 32;
  localparam int CharW   = 8;
  localparam int SkipW   = 2;
  localparam int DivCntW = $clog2(HashW);

  localparam logic [HashW-1:0] HashBase       = 32'd11;
  localparam logic [HashW-1:0] TableSizeReset = 32'd3000017;
  localparam logic [CharW-1:0] SkipMark       = 8'h3C;
  localparam logic [SkipW-1:0] SkipLen        = 2'd2;
  localparam logic [CharW-1:0] CaseOffset     = 8'h20;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  typedef struct packed {
    logic accept;    // absorb the current input byte
    logic div_step;  // one restoring-division iteration
    logic load_out;  // capture the remainder into the output register
  } cmd_t;

  typedef struct packed {
    logic div_last;  // the current iteration is the final one
  } status_t;

endpackage

[rtl/core/fchi_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fchi_datapath
// Character filter, Horner hash, size register and bit-serial modulo unit.
// ----------------------------------------------------------------------------
module fchi_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [fchi_pkg::HashW-1:0]    cfg_data,
  input  logic [fchi_pkg::CharW-1:0]    char_in,
  input  logic                          is_last,
  input  fchi_pkg::cmd_t                cmd,
  output fchi_pkg::status_t             status,
  output logic [fchi_pkg::HashW-1:0]    bucket_index
);
  import fchi_pkg::*;

  logic [HashW-1:0]   table_size;
  logic [HashW-1:0]   running_hash;
  logic [SkipW-1:0]   skip_count;
  logic [HashW-1:0]   dividend;
  logic [HashW-1:0]   rem;
  logic [DivCntW-1:0] bit_cnt;

  logic               is_lower;
  logic               is_digit;
  logic               is_upper;
  logic               keep;
  logic [CharW-1:0]   folded;
  logic [SkipW-1:0]   skip_next;
  logic [HashW-1:0]   hash_next;
  logic [HashW:0]     trial;
  logic               fits;

  always_comb begin
    is_lower  = (char_in >= 8'h61) && (char_in <= 8'h7A);
    is_digit  = (char_in >= 8'h30) && (char_in <= 8'h39);
    is_upper  = (char_in >= 8'h41) && (char_in <= 8'h5A);
    keep      = 1'b0;
    folded    = char_in;
    skip_next = skip_count;
    if (skip_count != '0) begin
      skip_next = skip_count - 1'b1;
    end else if (is_lower || is_digit) begin
      keep = 1'b1;
    end else if (is_upper) begin
      keep   = 1'b1;
      folded = char_in + CaseOffset;
    end else if (char_in == SkipMark) begin
      skip_next = SkipLen;
    end
    hash_next = running_hash;
    if (keep) begin
      hash_next = running_hash * HashBase + {{(HashW-CharW){1'b0}}, folded};
    end
  end

  // Restoring division: bring down one dividend bit and subtract when it fits.
  always_comb begin
    trial = {rem, dividend[HashW-1]};
    fits  = trial >= {1'b0, table_size};
  end

  assign status.div_last = (bit_cnt == DivCntW'(HashW - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size   <= TableSizeReset;
      running_hash <= '0;
      skip_count   <= '0;
      bit_cnt      <= '0;
    end else begin
      if (cfg_valid) begin
        table_size <= cfg_data;
      end
      if (cmd.accept) begin
        if (is_last) begin
          running_hash <= '0;
          skip_count   <= '0;
          bit_cnt      <= '0;
        end else begin
          running_hash <= hash_next;
          skip_count   <= skip_next;
        end
      end else if (cmd.div_step) begin
        bit_cnt <= bit_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && is_last) begin
      dividend <= hash_next;
      rem      <= '0;
    end else if (cmd.div_step) begin
      dividend <= {dividend[HashW-2:0], 1'b0};
      rem      <= fits ? HashW'(trial - {1'b0, table_size}) : trial[HashW-1:0];
    end
    if (cmd.load_out) begin
      bucket_index <= (table_size == '0) ? '0 : rem;
    end
  end

endmodule

[rtl/core/fchi_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fchi_ctrl
// Sequencer for byte intake, the modulo iterations and the output slot.
// ----------------------------------------------------------------------------
module fchi_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                is_last,
  input  logic                out_ready,
  input  fchi_pkg::status_t   status,
  output logic                in_ready,
  output logic                out_valid,
  output fchi_pkg::cmd_t      cmd
);
  import fchi_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (is_last) begin
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        // The finished remainder waits here until the output slot opens.
        if (slot_free) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[rtl/core/filtered_chunk_hash_index.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filtered_chunk_hash_index
// Filters a byte stream, hashes kept bytes base 11 and emits hash mod size.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                       Transfer
//  in        sink       in_valid/in_ready             char_in, is_last
//  out       source     out_valid/out_ready           bucket_index
//  cfg       sink       cfg_valid/cfg_ready           cfg_data (table_size)
//
//  For a last byte, the remainder comes from a restoring divider that
//  resolves one quotient bit per cycle, then is loaded into the output
//  register. Input is taken again while that result waits.
//  Reset clears the hash, the skip counter and the output slot, and sets
//  table_size to 3000017. A stalled output holds the controller in its final
//  state until the slot frees up.
// ----------------------------------------------------------------------------
`include "filtered_chunk_hash_index_assert.svh"

module filtered_chunk_hash_index (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [fchi_pkg::CharW-1:0]  char_in,
  input  logic                        is_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fchi_pkg::HashW-1:0]  bucket_index,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [fchi_pkg::HashW-1:0]  cfg_data
);
  import fchi_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  fchi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .is_last   (is_last),
    .out_ready (out_ready),
    .status    (status),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  fchi_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .char_in      (char_in),
    .is_last      (is_last),
    .cmd          (cmd),
    .status       (status),
    .bucket_index (bucket_index)
  );

  // A last byte starts the modulo unit, so intake must pause right after it.
  `FCHI_ASSERT_IMPL(a_last_pauses_intake, clk, rst, in_valid && in_ready && is_last |=> !in_ready, "intake not paused after last byte")
  // A new result only appears after the divider has held off intake.
  `FCHI_ASSERT_IMPL(a_result_follows_div, clk, rst, $rose(out_valid) |-> $past(!in_ready), "result appeared without a division")
  // Commands to the datapath never overlap.
  `FCHI_ASSERT_NEVER(a_cmd_overlap, clk, rst, !$onehot0(cmd), "datapath commands overlap")

endmodule
